// ----- hw/rtl/aae_pkg.sv -----
// Shared types and constants for the adaptive arithmetic encoder.
package aae_pkg;

  localparam int NSYM      = 258;
  localparam int SYM_AW    = 9;
  localparam int FREQ_W    = 14;
  localparam int BUF_DEPTH = 64;
  localparam int BUF_AW    = 6;
  localparam int CNT_W     = 7;

  localparam logic [SYM_AW-1:0] EOF_SYM  = 9'd257;
  localparam logic [SYM_AW-1:0] LAST_SYM = 9'd256;
  localparam logic [3:0]        BYTE_BITS = 4'd8;

  typedef enum logic [28:0] {
    ST_CLR    = 29'h0000001,
    ST_IDLE   = 29'h0000002,
    ST_LK     = 29'h0000004,
    ST_LK2    = 29'h0000008,
    ST_N_RD0  = 29'h0000010,
    ST_N_RD1  = 29'h0000020,
    ST_N_RD2  = 29'h0000040,
    ST_N_MUL  = 29'h0000080,
    ST_N_DIV  = 29'h0000100,
    ST_N_UPD  = 29'h0000200,
    ST_REN    = 29'h0000400,
    ST_PUT    = 29'h0000800,
    ST_EOF_F  = 29'h0001000,
    ST_EOF_B  = 29'h0002000,
    ST_SC_RD  = 29'h0004000,
    ST_SC_WR  = 29'h0008000,
    ST_SR0    = 29'h0010000,
    ST_SR1    = 29'h0020000,
    ST_SR_CHK = 29'h0040000,
    ST_SR_CMP = 29'h0080000,
    ST_SW0    = 29'h0100000,
    ST_SW1    = 29'h0200000,
    ST_SW2    = 29'h0400000,
    ST_SW3    = 29'h0800000,
    ST_INC    = 29'h1000000,
    ST_CU_CHK = 29'h2000000,
    ST_CU_WR  = 29'h4000000,
    ST_DR_RD  = 29'h8000000,
    ST_DR_OUT = 29'h10000000
  } aae_state_t;

endpackage

// ----- hw/rtl/adaptive_arithmetic_encoder_unit.sv -----
// Adaptive arithmetic encoder: model memories, interval coder and output byte buffer.
//
// Usage: the input channel carries one character per transfer (in_tdata) or an end
// mark (in_tuser = 1), which encodes the end-of-stream symbol, flushes the coder and
// restarts the model. Every completed code byte leaves on the output channel;
// out_tlast marks the last byte caused by one input and out_tuser carries the sticky
// follow-bit overflow flag. An input may cause no byte at all.
// Processing: one item at a time. Interval narrowing takes two multiply and
// restoring-divide passes, followed by the renormalization steps and the emitted
// bits. The model update walks the frequency and cumulative-count memories for the
// equal-frequency search and the count increments, and once more when the counts
// are halved; these memory walks set most of the time per character. Bytes are
// then drained from the buffer.
// Reset: a clearing pass loads the model tables; in_tready stays low
// until it ends. The same pass follows every end mark, after its bytes are drained.
// Stalls: the output register holds a byte while out_tready is low; the encoder
// waits in its drain phase and accepts a new item once the last byte is registered.
module adaptive_arithmetic_encoder_unit
  import aae_pkg::*;
#(
  parameter int CODE_BITS    = 16,
  parameter int FREQ_LIMIT   = 16383,
  parameter int FOLLOW_LIMIT = 480
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] end_mark
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] code_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] follow_overflow
);

  localparam int W   = CODE_BITS;
  localparam int PW  = CODE_BITS + 15;
  localparam int DCW = $clog2(PW + 1);
  localparam logic [W-1:0] HALF_PT = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] QTR1    = {2'b01, {(W-2){1'b0}}};
  localparam logic [W-1:0] QTR3    = {2'b11, {(W-2){1'b0}}};

  // Model memories and byte buffer.
  logic [FREQ_W-1:0] freq_mem [NSYM];
  logic [FREQ_W-1:0] cum_mem  [NSYM];
  logic [SYM_AW-1:0] cim_mem  [256];
  logic [7:0]        icm_mem  [NSYM];
  logic [7:0]        buf_mem  [BUF_DEPTH];

  logic [FREQ_W-1:0] freq_q, cum_q, freq_wd, cum_wd;
  logic [SYM_AW-1:0] cim_q, cim_wd;
  logic [7:0]        icm_q, icm_wd, buf_q, buf_wd;
  logic [SYM_AW-1:0] freq_ra, freq_wa, cum_ra, cum_wa, icm_ra, icm_wa;
  logic [7:0]        cim_ra, cim_wa;
  logic [BUF_AW-1:0] buf_ra, buf_wa;
  logic              freq_we, cum_we, cim_we, icm_we, buf_we;

  aae_state_t        state_r, state_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              eof_r, eof_nxt;
  logic [SYM_AW-1:0] sym_r, sym_nxt, idx_r, idx_nxt;
  logic [W-1:0]      low_r, low_nxt, high_r, high_nxt;
  logic [8:0]        pend_r, pend_nxt;
  logic [7:0]        bsr_r, bsr_nxt;
  logic [3:0]        bfree_r, bfree_nxt;
  logic              ovf_r, ovf_nxt;
  logic [FREQ_W-1:0] tot_r, tot_nxt, chi_r, chi_nxt, clo_r, clo_nxt, fs_r, fs_nxt;
  logic              sel_r, sel_nxt;
  logic [W:0]        q1_r, q1_nxt;
  logic [PW-1:0]     quo_r, quo_nxt;
  logic [FREQ_W-1:0] rem_r, rem_nxt;
  logic [DCW-1:0]    dcnt_r, dcnt_nxt;
  logic              bit_r, bit_nxt, first_r, first_nxt, reteof_r, reteof_nxt;
  logic [FREQ_W:0]   acc_r, acc_nxt;
  logic [7:0]        ci_r, ci_nxt, cs_r, cs_nxt;
  logic [CNT_W-1:0]  bcnt_r, bcnt_nxt, rd_r, rd_nxt;
  logic              ovalid_r, ovalid_nxt, olast_r, olast_nxt, ouser_r, ouser_nxt;
  logic [7:0]        odata_r, odata_nxt;

  // Datapath helpers.
  logic [W:0]        span;
  logic [PW-1:0]     prod;
  logic [FREQ_W:0]   dtrial;
  logic [FREQ_W-1:0] divisor;
  logic              dge;
  logic              pb;
  logic [7:0]        put_bsr;
  logic [3:0]        put_free;
  logic [8:0]        put_left;
  logic [FREQ_W-1:0] half_f;
  logic [W+1:0]      new_high;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = ouser_r;

  assign span    = {1'b0, high_r} - {1'b0, low_r} + (W+1)'(1);
  assign prod    = PW'(span) * PW'(sel_r ? clo_r : chi_r);
  assign divisor = (tot_r == '0) ? FREQ_W'(1) : tot_r;
  assign dtrial  = {rem_r, quo_r[PW-1]};
  assign dge     = dtrial >= {1'b0, divisor};
  assign pb       = first_r ? bit_r : ~bit_r;
  assign put_bsr  = {pb, bsr_r[7:1]};
  assign put_free = bfree_r - 4'd1;
  assign put_left = first_r ? pend_r : pend_r - 9'd1;
  assign half_f   = FREQ_W'(({1'b0, freq_q} + (FREQ_W+1)'(1)) >> 1);
  assign new_high = {2'b00, low_r} + {1'b0, q1_r} - (W+2)'(1);

  always_comb begin
    state_nxt  = state_r;
    byte_nxt   = byte_r;
    eof_nxt    = eof_r;
    sym_nxt    = sym_r;
    idx_nxt    = idx_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    pend_nxt   = pend_r;
    bsr_nxt    = bsr_r;
    bfree_nxt  = bfree_r;
    ovf_nxt    = ovf_r;
    tot_nxt    = tot_r;
    chi_nxt    = chi_r;
    clo_nxt    = clo_r;
    fs_nxt     = fs_r;
    sel_nxt    = sel_r;
    q1_nxt     = q1_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dcnt_nxt   = dcnt_r;
    bit_nxt    = bit_r;
    first_nxt  = first_r;
    reteof_nxt = reteof_r;
    acc_nxt    = acc_r;
    ci_nxt     = ci_r;
    cs_nxt     = cs_r;
    bcnt_nxt   = bcnt_r;
    rd_nxt     = rd_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    ouser_nxt  = ouser_r;
    ovalid_nxt = ovalid_r & ~out_tready;

    freq_we = 1'b0; freq_wa = idx_r; freq_wd = '0; freq_ra = '0;
    cum_we  = 1'b0; cum_wa  = idx_r; cum_wd  = '0; cum_ra  = '0;
    icm_we  = 1'b0; icm_wa  = idx_r; icm_wd  = '0; icm_ra  = '0;
    cim_we  = 1'b0; cim_wa  = idx_r[7:0]; cim_wd = '0; cim_ra = byte_r;
    buf_we  = 1'b0; buf_wa  = bcnt_r[BUF_AW-1:0]; buf_wd = '0;
    buf_ra  = rd_r[BUF_AW-1:0];

    unique case (state_r)
      ST_CLR: begin
        freq_we = 1'b1;
        freq_wd = (idx_r == '0) ? FREQ_W'(0) : FREQ_W'(1);
        cum_we  = 1'b1;
        cum_wd  = FREQ_W'(EOF_SYM - idx_r);
        icm_we  = 1'b1;
        icm_wd  = (idx_r != '0 && idx_r <= LAST_SYM) ? 8'(idx_r - 9'd1) : 8'd0;
        cim_we  = (idx_r < LAST_SYM);
        cim_wd  = idx_r + 9'd1;
        if (idx_r == EOF_SYM) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 9'd1;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          byte_nxt  = in_tdata;
          eof_nxt   = in_tuser;
          sym_nxt   = EOF_SYM;
          state_nxt = in_tuser ? ST_N_RD0 : ST_LK;
        end
      end
      ST_LK: begin
        state_nxt = ST_LK2;
      end
      ST_LK2: begin
        if (cim_q == '0) begin
          sym_nxt = 9'd1;
        end else if (cim_q > LAST_SYM) begin
          sym_nxt = LAST_SYM;
        end else begin
          sym_nxt = cim_q;
        end
        state_nxt = ST_N_RD0;
      end
      ST_N_RD0: begin
        state_nxt = ST_N_RD1;
      end
      ST_N_RD1: begin
        cum_ra    = sym_r - 9'd1;
        tot_nxt   = cum_q;
        state_nxt = ST_N_RD2;
      end
      ST_N_RD2: begin
        cum_ra    = sym_r;
        chi_nxt   = cum_q;
        sel_nxt   = 1'b0;
        state_nxt = ST_N_MUL;
      end
      ST_N_MUL: begin
        if (!sel_r) begin
          clo_nxt = cum_q;
        end
        quo_nxt   = prod;
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = ST_N_DIV;
      end
      ST_N_DIV: begin
        rem_nxt  = dge ? FREQ_W'(dtrial - {1'b0, divisor}) : dtrial[FREQ_W-1:0];
        quo_nxt  = {quo_r[PW-2:0], dge};
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(PW - 1)) begin
          if (!sel_r) begin
            q1_nxt    = quo_nxt[W:0];
            sel_nxt   = 1'b1;
            state_nxt = ST_N_MUL;
          end else begin
            state_nxt = ST_N_UPD;
          end
        end
      end
      ST_N_UPD: begin
        high_nxt  = new_high[W-1:0];
        low_nxt   = low_r + quo_r[W-1:0];
        sel_nxt   = 1'b0;
        state_nxt = ST_REN;
      end
      ST_REN: begin
        // Renormalize: emit a settled top bit or defer one near the middle.
        priority if (high_r < HALF_PT) begin
          bit_nxt    = 1'b0;
          first_nxt  = 1'b1;
          reteof_nxt = 1'b0;
          low_nxt    = {low_r[W-2:0], 1'b0};
          high_nxt   = {high_r[W-2:0], 1'b1};
          state_nxt  = ST_PUT;
        end else if (low_r >= HALF_PT) begin
          bit_nxt    = 1'b1;
          first_nxt  = 1'b1;
          reteof_nxt = 1'b0;
          low_nxt    = {low_r[W-2:0], 1'b0};
          high_nxt   = {high_r[W-2:0], 1'b1};
          state_nxt  = ST_PUT;
        end else if (low_r >= QTR1 && high_r < QTR3) begin
          if (pend_r >= 9'(FOLLOW_LIMIT)) begin
            ovf_nxt = 1'b1;
          end else begin
            pend_nxt = pend_r + 9'd1;
          end
          low_nxt  = {low_r[W-2:0] - QTR1[W-2:0], 1'b0};
          high_nxt = {high_r[W-2:0] - QTR1[W-2:0], 1'b1};
        end else begin
          if (eof_r) begin
            state_nxt = ST_EOF_F;
          end else if (tot_r == FREQ_W'(FREQ_LIMIT)) begin
            idx_nxt   = EOF_SYM;
            acc_nxt   = '0;
            state_nxt = ST_SC_RD;
          end else begin
            state_nxt = ST_SR0;
          end
        end
      end
      ST_PUT: begin
        // One bit per cycle: the decided bit, then its pending follow bits.
        bsr_nxt = put_bsr;
        if (put_free == '0) begin
          bfree_nxt = BYTE_BITS;
          if (bcnt_r < CNT_W'(BUF_DEPTH)) begin
            buf_we   = 1'b1;
            buf_wd   = put_bsr;
            bcnt_nxt = bcnt_r + CNT_W'(1);
          end
        end else begin
          bfree_nxt = put_free;
        end
        first_nxt = 1'b0;
        pend_nxt  = put_left;
        if (put_left == '0) begin
          state_nxt = reteof_r ? ST_EOF_B : ST_REN;
        end
      end
      ST_EOF_F: begin
        if (pend_r >= 9'(FOLLOW_LIMIT)) begin
          ovf_nxt = 1'b1;
        end else begin
          pend_nxt = pend_r + 9'd1;
        end
        bit_nxt    = (low_r >= QTR1);
        first_nxt  = 1'b1;
        reteof_nxt = 1'b1;
        state_nxt  = ST_PUT;
      end
      ST_EOF_B: begin
        if (bcnt_r < CNT_W'(BUF_DEPTH)) begin
          buf_we   = 1'b1;
          buf_wd   = 8'(bsr_r >> bfree_r);
          bcnt_nxt = bcnt_r + CNT_W'(1);
        end
        state_nxt = ST_DR_RD;
      end
      ST_SC_RD: begin
        freq_ra   = idx_r;
        state_nxt = ST_SC_WR;
      end
      ST_SC_WR: begin
        // Halve counts from the top down and rebuild the cumulative table.
        freq_we = 1'b1;
        freq_wd = half_f;
        cum_we  = 1'b1;
        cum_wd  = acc_r[FREQ_W-1:0];
        acc_nxt = acc_r + {1'b0, half_f};
        if (idx_r == '0) begin
          state_nxt = ST_SR0;
        end else begin
          idx_nxt   = idx_r - 9'd1;
          state_nxt = ST_SC_RD;
        end
      end
      ST_SR0: begin
        freq_ra   = sym_r;
        state_nxt = ST_SR1;
      end
      ST_SR1: begin
        fs_nxt    = freq_q;
        idx_nxt   = sym_r;
        state_nxt = ST_SR_CHK;
      end
      ST_SR_CHK: begin
        if (idx_r <= 9'd1) begin
          state_nxt = ST_SW0;
        end else begin
          freq_ra   = idx_r - 9'd1;
          state_nxt = ST_SR_CMP;
        end
      end
      ST_SR_CMP: begin
        if (freq_q == fs_r) begin
          idx_nxt   = idx_r - 9'd1;
          state_nxt = ST_SR_CHK;
        end else begin
          state_nxt = ST_SW0;
        end
      end
      ST_SW0: begin
        if (idx_r < sym_r) begin
          icm_ra    = idx_r;
          state_nxt = ST_SW1;
        end else begin
          state_nxt = ST_INC;
        end
      end
      ST_SW1: begin
        icm_ra    = sym_r;
        ci_nxt    = icm_q;
        state_nxt = ST_SW2;
      end
      ST_SW2: begin
        cs_nxt    = icm_q;
        icm_we    = 1'b1;
        icm_wa    = idx_r;
        icm_wd    = icm_q;
        cim_we    = 1'b1;
        cim_wa    = ci_r;
        cim_wd    = sym_r;
        state_nxt = ST_SW3;
      end
      ST_SW3: begin
        icm_we    = 1'b1;
        icm_wa    = sym_r;
        icm_wd    = ci_r;
        cim_we    = 1'b1;
        cim_wa    = cs_r;
        cim_wd    = idx_r;
        state_nxt = ST_INC;
      end
      ST_INC: begin
        freq_we   = 1'b1;
        freq_wd   = fs_r + FREQ_W'(1);
        state_nxt = ST_CU_CHK;
      end
      ST_CU_CHK: begin
        if (idx_r == '0) begin
          state_nxt = ST_DR_RD;
        end else begin
          cum_ra    = idx_r - 9'd1;
          idx_nxt   = idx_r - 9'd1;
          state_nxt = ST_CU_WR;
        end
      end
      ST_CU_WR: begin
        cum_we    = 1'b1;
        cum_wd    = cum_q + FREQ_W'(1);
        state_nxt = ST_CU_CHK;
      end
      ST_DR_RD: begin
        if (rd_r == bcnt_r) begin
          bcnt_nxt = '0;
          rd_nxt   = '0;
          if (eof_r) begin
            idx_nxt   = '0;
            low_nxt   = '0;
            high_nxt  = '1;
            pend_nxt  = '0;
            bsr_nxt   = '0;
            bfree_nxt = BYTE_BITS;
            ovf_nxt   = 1'b0;
            eof_nxt   = 1'b0;
            state_nxt = ST_CLR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_DR_OUT;
        end
      end
      ST_DR_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = buf_q;
          olast_nxt  = (rd_r + CNT_W'(1) == bcnt_r);
          ouser_nxt  = ovf_r;
          rd_nxt     = rd_r + CNT_W'(1);
          state_nxt  = ST_DR_RD;
        end
      end
      default: begin
        state_nxt = ST_CLR;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (freq_we) begin
      freq_mem[freq_wa] <= freq_wd;
    end
    freq_q <= freq_mem[freq_ra];
  end

  always_ff @(posedge clk) begin
    if (cum_we) begin
      cum_mem[cum_wa] <= cum_wd;
    end
    cum_q <= cum_mem[cum_ra];
  end

  always_ff @(posedge clk) begin
    if (cim_we) begin
      cim_mem[cim_wa] <= cim_wd;
    end
    cim_q <= cim_mem[cim_ra];
  end

  always_ff @(posedge clk) begin
    if (icm_we) begin
      icm_mem[icm_wa] <= icm_wd;
    end
    icm_q <= icm_mem[icm_ra];
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_wa] <= buf_wd;
    end
    buf_q <= buf_mem[buf_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      idx_r    <= '0;
      eof_r    <= 1'b0;
      low_r    <= '0;
      high_r   <= '1;
      pend_r   <= '0;
      bsr_r    <= '0;
      bfree_r  <= BYTE_BITS;
      ovf_r    <= 1'b0;
      sel_r    <= 1'b0;
      first_r  <= 1'b0;
      reteof_r <= 1'b0;
      bcnt_r   <= '0;
      rd_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      eof_r    <= eof_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      pend_r   <= pend_nxt;
      bsr_r    <= bsr_nxt;
      bfree_r  <= bfree_nxt;
      ovf_r    <= ovf_nxt;
      sel_r    <= sel_nxt;
      first_r  <= first_nxt;
      reteof_r <= reteof_nxt;
      bcnt_r   <= bcnt_nxt;
      rd_r     <= rd_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    sym_r   <= sym_nxt;
    tot_r   <= tot_nxt;
    chi_r   <= chi_nxt;
    clo_r   <= clo_nxt;
    fs_r    <= fs_nxt;
    q1_r    <= q1_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dcnt_r  <= dcnt_nxt;
    bit_r   <= bit_nxt;
    acc_r   <= acc_nxt;
    ci_r    <= ci_nxt;
    cs_r    <= cs_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
    ouser_r <= ouser_nxt;
  end

endmodule

// ----- bench/adaptive_arithmetic_encoder_unit_tb.sv -----
// Self-checking testbench for the adaptive arithmetic encoder unit.
`timescale 1ns / 100ps

// Scoreboard: holds a software copy of the coder and the queue of code bytes it predicts.
class aae_scoreboard;
  localparam int TOPV = 65535;
  localparam int Q1 = 16384;
  localparam int HALFV = 32768;
  localparam int Q3 = 49152;
  localparam int FRQ_LIM = 16383;
  localparam int FOL_LIM = 480;

  int unsigned freq[258];
  int unsigned cum[258];
  int unsigned c2i[256];
  int unsigned i2c[258];
  longint lo, hi;
  int unsigned follow, shreg, nfree, ovf;

  // Predicted bytes: code byte, last-of-run flag and overflow flag.
  logic [7:0] code_q[$];
  bit         last_q[$];
  bit         ovf_q[$];
  int         first_of_step;
  int         errors;
  int         bytes_seen;
  int         ovf_seen_cnt;

  function new();
    errors = 0;
    bytes_seen = 0;
    ovf_seen_cnt = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 256; i++) c2i[i] = i + 1;
    i2c[0] = 0;
    for (int i = 0; i < 256; i++) i2c[i + 1] = i;
    i2c[257] = 0;
    for (int i = 0; i < 258; i++) begin
      freq[i] = 1;
      cum[i] = 257 - i;
    end
    freq[0] = 0;
    lo = 0;
    hi = TOPV;
    follow = 0;
    shreg = 0;
    nfree = 8;
    ovf = 0;
  endfunction

  function void push_byte(int unsigned b);
    code_q.push_back(b[7:0]);
    last_q.push_back(1'b0);
    ovf_q.push_back(1'b0);
  endfunction

  function void shift_bit(int unsigned b);
    shreg = (shreg >> 1) & 8'h7f;
    if (b != 0) shreg |= 8'h80;
    nfree = nfree - 1;
    if (nfree == 0) begin
      push_byte(shreg);
      nfree = 8;
    end
  endfunction

  function void shift_with_follow(int unsigned b);
    shift_bit(b);
    while (follow > 0) begin
      shift_bit(b ? 0 : 1);
      follow--;
    end
  endfunction

  // Pending follow bits saturate and set the sticky overflow flag.
  function void bump_follow();
    if (follow >= FOL_LIM) ovf = 1;
    else follow++;
  endfunction

  function void narrow_interval(int unsigned s);
    longint span, tot;
    span = hi - lo + 1;
    tot = cum[0];
    if (tot == 0) tot = 1;
    hi = lo + (span * cum[s - 1]) / tot - 1;
    lo = lo + (span * cum[s]) / tot;
    forever begin
      if (hi < HALFV) begin
        shift_with_follow(0);
      end else if (lo >= HALFV) begin
        shift_with_follow(1);
        lo -= HALFV;
        hi -= HALFV;
      end else if (lo >= Q1 && hi < Q3) begin
        bump_follow();
        lo -= Q1;
        hi -= Q1;
      end else begin
        break;
      end
      lo = 2 * lo;
      hi = 2 * hi + 1;
    end
  endfunction

  function void adapt_counts(int unsigned s);
    int i;
    int unsigned acc, ci, cs;
    if (cum[0] == FRQ_LIM) begin
      acc = 0;
      for (i = 257; i >= 0; i--) begin
        freq[i] = (freq[i] + 1) / 2;
        cum[i] = acc;
        acc += freq[i];
      end
    end
    i = s;
    while (i > 1 && freq[i] == freq[i - 1]) i--;
    if (i < s) begin
      ci = i2c[i] & 8'hff;
      cs = i2c[s] & 8'hff;
      i2c[i] = cs;
      i2c[s] = ci;
      c2i[ci] = s;
      c2i[cs] = i;
    end
    freq[i] = (freq[i] + 1) & 14'h3fff;
    while (i > 0) begin
      i--;
      cum[i] = (cum[i] + 1) & 14'h3fff;
    end
  endfunction

  // Called for every accepted input transfer.
  function void note_input(logic [7:0] data_byte, logic end_mark);
    int unsigned s;
    first_of_step = code_q.size();
    if (end_mark) begin
      narrow_interval(257);
      bump_follow();
      shift_with_follow(lo < Q1 ? 0 : 1);
      push_byte((shreg >> nfree) & 8'hff);
    end else begin
      s = c2i[data_byte] & 9'h1ff;
      if (s < 1) s = 1;
      if (s > 256) s = 256;
      narrow_interval(s);
      adapt_counts(s);
    end
    for (int k = first_of_step; k < code_q.size(); k++) begin
      last_q[k] = (k == code_q.size() - 1);
      ovf_q[k] = ovf[0];
    end
    if (end_mark) restart();
  endfunction

  // Called for every accepted output transfer.
  function void check_result(logic [7:0] code_byte, logic last_flag, logic ovf_flag);
    logic [7:0] exp_code;
    bit exp_last, exp_ovf;
    bytes_seen++;
    if (ovf_flag) ovf_seen_cnt++;
    if (code_q.size() == 0) begin
      $display("%0t: unexpected byte %02h last %0d ovf %0d", $time, code_byte,
               last_flag, ovf_flag);
      errors++;
      return;
    end
    exp_code = code_q.pop_front();
    exp_last = last_q.pop_front();
    exp_ovf = ovf_q.pop_front();
    if (code_byte !== exp_code) begin
      $display("%0t: code byte expected %02h actual %02h", $time, exp_code, code_byte);
      errors++;
    end
    if (last_flag !== exp_last) begin
      $display("%0t: last flag expected %0d actual %0d", $time, exp_last, last_flag);
      errors++;
    end
    if (ovf_flag !== exp_ovf) begin
      $display("%0t: overflow flag expected %0d actual %0d", $time, exp_ovf, ovf_flag);
      errors++;
    end
  endfunction
endclass

module adaptive_arithmetic_encoder_unit_tb;
  import aae_pkg::*;

  // Slowest item: a full model walk plus 64 bytes at a long stall each,
  // for about 380 items; the limit sits several times above that.
  localparam int CYCLE_LIMIT = 20000000;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  aae_scoreboard coder_model;
  int cycles;
  int items_sent;
  int end_marks_sent;
  bit hold_off_on;

  adaptive_arithmetic_encoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    coder_model = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    hold_off_on = 1'b0;
    items_sent = 0;
    end_marks_sent = 0;
    cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Scoreboard hooks sample both channels at the rising edge where a transfer happens.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) coder_model.note_input(in_tdata, in_tuser);
      if (out_tvalid && out_tready) coder_model.check_result(out_tdata, out_tlast, out_tuser);
    end
  end

  // Watchdog: ends the run with a failure once the cycle limit is reached.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("adaptive_arithmetic_encoder_unit_tb NOT OK");
      $finish;
    end
  end

  // Receiver: a random stall pattern with stall-free stretches, plus one long
  // hold-off so the encoder waits in its drain phase and the input side backs up.
  initial begin : receiver
    int mode;
    int len;
    @(posedge rst_n);
    forever begin
      if (hold_off_on) begin
        out_tready <= 1'b0;
        repeat (6000) @(posedge clk);
        hold_off_on = 1'b0;
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 40);
      repeat (len) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk);
      end
    end
  end

  // Offers one item and holds it until the transfer completes.
  task automatic send_item(input logic [7:0] data_byte, input logic end_mark);
    in_tvalid <= 1'b1;
    in_tdata <= data_byte;
    in_tuser <= end_mark;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (end_mark) end_marks_sent++;
  endtask

  // Drops valid for a random gap, sometimes none at all.
  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk);
    end
  endtask

  // Picks a byte from a skewed alphabet so the model reorders and counts build up.
  function automatic logic [7:0] pick_char(int alphabet);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, alphabet - 1) + 8'h41);
  endfunction

  initial begin : sender
    int burst;
    int run_len;
    int alphabet;
    logic [7:0] directed [0:11];
    directed = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'h7f, 8'hfe,
                 8'h00, 8'h00, 8'hff, 8'hff};
    @(posedge rst_n);

    // Directed: an end mark with an empty byte, extreme characters, repeated
    // characters that swap places in the model, and end marks between them.
    send_item(8'h00, 1'b1);
    foreach (directed[k]) send_item(directed[k], 1'b0);
    send_item(8'hff, 1'b1);
    send_item(8'h42, 1'b0);
    send_item(8'h42, 1'b1);
    sender_gap();

    // Long receiver hold-off while the sender keeps going.
    hold_off_on = 1'b1;
    repeat (40) send_item(pick_char(4), 1'b0);
    send_item(8'h00, 1'b1);

    // Random runs of text ending in an end mark, with the odd end mark inside a run.
    while (items_sent < 380) begin
      run_len = $urandom_range(1, 40);
      alphabet = $urandom_range(1, 26);
      burst = $urandom_range(1, 10);
      for (int k = 0; k < run_len; k++) begin
        send_item(pick_char(alphabet), ($urandom_range(0, 50) == 0));
        if (--burst == 0) begin
          sender_gap();
          burst = $urandom_range(1, 10);
        end
      end
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (coder_model.code_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d items with %0d end marks; checked %0d code bytes (%0d flagged).",
             items_sent, end_marks_sent, coder_model.bytes_seen, coder_model.ovf_seen_cnt);
    if (coder_model.errors == 0 && coder_model.code_q.size() == 0) begin
      $display("adaptive_arithmetic_encoder_unit_tb OK");
    end else begin
      $display("adaptive_arithmetic_encoder_unit_tb NOT OK");
    end
    $finish;
  end
endmodule
